// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/gsg_pkg.sv
// ----------------------------------------------------------------------------
// gsg_pkg
// Types, codes and a helper function shared by the swipe gesture detector.
// ----------------------------------------------------------------------------
package gsg_pkg;

   localparam int WINDOW_DEPTH_DEF = 8;
   localparam int RATE_W           = 16;
   localparam int MAG_W            = RATE_W + 1;
   localparam int THR_W            = 15;
   localparam int GEST_W           = 3;
   localparam int CSR_IDX_W        = 1;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(4000);

   // Register indexes of the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_THR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_THR = 1'b1;

   // Gesture codes on the result channel.
   localparam logic [GEST_W-1:0] GEST_DOWN   = 3'd0;
   localparam logic [GEST_W-1:0] GEST_LEFT   = 3'd1;
   localparam logic [GEST_W-1:0] GEST_RIGHT  = 3'd2;
   localparam logic [GEST_W-1:0] GEST_DOUBLE = 3'd3;
   localparam logic [GEST_W-1:0] GEST_LR     = 3'd4;

   typedef enum logic [1:0] {
      MOVE_NONE,
      MOVE_DOWN,
      MOVE_LEFT,
      MOVE_RIGHT
   } move_type;

   // Data handed from one window cell to the next.
   typedef struct packed {
      logic                     tok;
      logic signed [RATE_W-1:0] pitch_best;
      logic signed [RATE_W-1:0] yaw_best;
   } link_type;

   // Exact magnitude of a signed rate, one bit wider so -32768 fits.
   function automatic logic [MAG_W-1:0] mag17(input logic signed [RATE_W-1:0] v);
      logic [MAG_W-1:0] ext;
      ext = {v[RATE_W-1], v};
      return v[RATE_W-1] ? (~ext + MAG_W'(1)) : ext;
   endfunction

endpackage

// File: rtl/gsg_cell.sv
// ----------------------------------------------------------------------------
// gsg_cell
// One window slot: holds a pitch and yaw sample and passes the running peak on.
// ----------------------------------------------------------------------------
module gsg_cell
   import gsg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic signed [RATE_W-1:0] wr_pitch,
   input  logic signed [RATE_W-1:0] wr_yaw,
   input  link_type                 link_in,
   output link_type                 link_out
);

   logic signed [RATE_W-1:0] pitch_ff, yaw_ff;
   logic                     tok_ff;
   logic signed [RATE_W-1:0] pitch_best_ff, pitch_best_in;
   logic signed [RATE_W-1:0] yaw_best_ff, yaw_best_in;

   // The stored sample replaces the running peak only on a strictly larger
   // magnitude, so the slot nearest the start of the chain wins a tie.
   always_comb begin
      pitch_best_in = (mag17(pitch_ff) > mag17(link_in.pitch_best)) ?
                      pitch_ff : link_in.pitch_best;
      yaw_best_in   = (mag17(yaw_ff) > mag17(link_in.yaw_best)) ?
                      yaw_ff : link_in.yaw_best;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= '0;
         yaw_ff   <= '0;
         tok_ff   <= 1'b0;
      end else begin
         tok_ff <= link_in.tok;
         if (wr_en) begin
            pitch_ff <= wr_pitch;
            yaw_ff   <= wr_yaw;
         end
      end
   end

   always_ff @(posedge clock) begin
      pitch_best_ff <= pitch_best_in;
      yaw_best_ff   <= yaw_best_in;
   end

   assign link_out = '{tok: tok_ff, pitch_best: pitch_best_ff, yaw_best: yaw_best_ff};

endmodule

// File: rtl/gyro_swipe_gesture_detector.sv
// ----------------------------------------------------------------------------
// gyro_swipe_gesture_detector
// Classifies gyroscope samples into swipe gestures over a window of samples.
// ----------------------------------------------------------------------------
// Each accepted beat carries one gyroscope sample. The block finds the peak
// pitch and yaw rates over the WINDOW_DEPTH earlier samples, updates the
// current move (down, left or right, with a latch that keeps a side swipe from
// flipping direction) and, when a sample shows no significant motion, emits
// one gesture code for the move that just ended. The sample is then stored in
// the window. The sample channel stays stalled from acceptance until the
// decision commits: the peak search runs through the chain of window cells
// one slot per cycle, then a decision state; a decision that has a result
// waits while the previous result is still stalled on the output. The
// window is cleared by reset. The user must write thresholds through the
// csr port only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module gyro_swipe_gesture_detector
   import gsg_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // sample channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [RATE_W-1:0] req_pitch_rate,
   input  logic signed [RATE_W-1:0] req_yaw_rate,
   input  logic                     req_b_held,
   // gesture channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [GEST_W-1:0]        rsp_gesture,
   // threshold registers
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [THR_W-1:0]         csr_wdata
);

   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type                state_ff, state_in;
   move_type                 move_ff, move_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GEST_W-1:0]        gesture_ff, gesture_in;
   logic [THR_W-1:0]         down_thr_ff, down_thr_in;
   logic [THR_W-1:0]         side_thr_ff, side_thr_in;

   // Sample and peaks held for the decision.
   logic signed [RATE_W-1:0] pitch_ff, yaw_ff;
   logic                     held_ff;
   logic signed [RATE_W-1:0] pitch_peak_ff, yaw_peak_ff;

   logic                     accept;
   logic                     commit;
   logic                     emit;
   logic                     is_down, is_side;
   logic [MAG_W-1:0]         pitch_mag, yaw_mag;
   logic [GEST_W-1:0]        code;
   logic [WINDOW_DEPTH-1:0]  wr_en;
   link_type                 link [WINDOW_DEPTH+1];

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   // The peak search starts at slot zero with a zero peak.
   assign link[0] = '{tok: accept, pitch_best: '0, yaw_best: '0};

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      assign wr_en[i] = commit && (slot_ff == SLOT_W'(i));
      gsg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en[i]),
         .wr_pitch (pitch_ff),
         .wr_yaw   (yaw_ff),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   // Classification of the window peaks.
   always_comb begin
      pitch_mag = mag17(pitch_peak_ff);
      yaw_mag   = mag17(yaw_peak_ff);
      is_down   = (pitch_mag > yaw_mag) &&
                  ($signed({pitch_peak_ff[RATE_W-1], pitch_peak_ff}) >
                   $signed({2'b00, down_thr_ff}));
      is_side   = (yaw_mag > {2'b00, side_thr_ff});
      emit      = !is_down && !is_side && (move_ff != MOVE_NONE);
      if (held_ff) begin
         code = (move_ff == MOVE_DOWN) ? GEST_DOUBLE : GEST_LR;
      end else begin
         case (move_ff)
            MOVE_DOWN:  code = GEST_DOWN;
            MOVE_LEFT:  code = GEST_LEFT;
            MOVE_RIGHT: code = GEST_RIGHT;
            default:    code = GEST_DOWN;
         endcase
      end
   end

   // A decision with a result may go ahead when the output register is free
   // or is being emptied in this cycle.
   assign commit = (state_ff == ST_DECIDE) && (!emit || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      move_in      = move_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      gesture_in   = gesture_ff;
      down_thr_in  = down_thr_ff;
      side_thr_in  = side_thr_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_DOWN_THR: down_thr_in = csr_wdata;
            CSR_SIDE_THR: side_thr_in = csr_wdata;
            default:      ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (link[WINDOW_DEPTH].tok) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (commit) begin
               state_in = ST_IDLE;
               slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
               if (is_down) begin
                  move_in = MOVE_DOWN;
               end else if (is_side) begin
                  // A positive yaw peak means left unless a right swipe runs;
                  // anything else means right unless a left swipe runs.
                  if (!yaw_peak_ff[RATE_W-1] && (yaw_peak_ff != '0) &&
                      (move_ff != MOVE_RIGHT)) begin
                     move_in = MOVE_LEFT;
                  end else if (move_ff != MOVE_LEFT) begin
                     move_in = MOVE_RIGHT;
                  end
               end else begin
                  move_in = MOVE_NONE;
                  if (emit) begin
                     rsp_valid_in = 1'b1;
                     gesture_in   = code;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         move_ff      <= MOVE_NONE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         down_thr_ff  <= THR_RESET;
         side_thr_ff  <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         move_ff      <= move_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         down_thr_ff  <= down_thr_in;
         side_thr_ff  <= side_thr_in;
      end
   end

   // Payload registers: sample on acceptance, peaks at the end of the chain.
   always_ff @(posedge clock) begin
      gesture_ff <= gesture_in;
      if (accept) begin
         pitch_ff <= req_pitch_rate;
         yaw_ff   <= req_yaw_rate;
         held_ff  <= req_b_held;
      end
      if (state_ff == ST_SCAN && link[WINDOW_DEPTH].tok) begin
         pitch_peak_ff <= link[WINDOW_DEPTH].pitch_best;
         yaw_peak_ff   <= link[WINDOW_DEPTH].yaw_best;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = gesture_ff;

endmodule

// File: rtl/gsg_checker.sv
// ----------------------------------------------------------------------------
// gsg_checker
// Port-level checks on the swipe gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsg_checker
   import gsg_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [GEST_W-1:0]        rsp_gesture
);

   // Only the five defined gesture codes ever leave the block.
   `ASSERT_CLK_RST(a_gesture_code, clock, reset, rsp_valid |-> (rsp_gesture <= GEST_LR), "gesture code out of range")

   // A result needs a full window scan, so none appears right after a sample.
   `ASSERT_CLK_RST(a_no_quick_rsp, clock, reset, (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid, "result too soon after sample")

   // Reset empties the output register.
   `ASSERT_CLK(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result is held.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "stalled result dropped")

endmodule

bind gyro_swipe_gesture_detector gsg_checker u_gsg_checker (.*);
